>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/dslpd_pkg.sv
package dslpd_pkg;

    localparam int CNT_W = 17;
    localparam int THR_W = 16;
    localparam logic [CNT_W-1:0] ELAPSED_MAX = {CNT_W{1'b1}};

    localparam logic [THR_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [THR_W-1:0] LONG_RST     = 16'd1000;
    localparam logic             ACTIVE_LOW_RST = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_SHORT    = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG       = 2'd1,
        CFG_ACTIVE_LOW = 2'd2
    } cfg_idx_t;

endpackage

>>> rtl/core/debounced_short_long_press_detector_core.sv
// channel   | direction | payload
// s_axis    | in        | tdata[0] pin_level, [7:1] zero
// m_axis    | out       | tdata[0] short_press, [1] long_press, [3:2] phase, [7:4] zero
// cfg       | in        | cfg_index selects register, cfg_data write value
//
// One tick per cycle while m_axis is not stalled: each beat updates the phase machine in the cycle it is taken.
// The result sits in a single output register; a new tick is taken while that
// register is empty or being drained in the same cycle.
// Reset (rst_n low, async) gives idle phase, cleared flags and counter, default config.
// A stall on m_axis holds the result and stops s_axis; cfg is always ready.
module debounced_short_long_press_detector_core
    import dslpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] short_press, [1] long_press, [3:2] phase, [7:4] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [THR_W-1:0] debounce_reg;
    logic [THR_W-1:0] long_reg;
    logic             active_low_reg;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] elapsed_reg, elapsed_next;
    logic             short_reg, short_next;
    logic             long_flag_reg, long_flag_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg;

    logic             in_beat;
    logic             active;
    logic [CNT_W-1:0] elapsed_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_reg       <= LONG_RST;
            active_low_reg <= ACTIVE_LOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                CFG_LONG:       long_reg       <= cfg_data;
                CFG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign active      = s_axis_tdata[0] ^ active_low_reg;
    // saturating tick count
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                       : elapsed_reg + CNT_W'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        short_next     = short_reg;
        long_flag_next = long_flag_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        if (in_beat)
        begin
            m_valid_next = 1'b1;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    short_next     = 1'b0;
                    long_flag_next = 1'b0;
                    if (active)
                    begin
                        elapsed_next = '0;
                        phase_next   = PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (!active)
                        phase_next = PH_IDLE;
                    else if (elapsed_inc > {1'b0, debounce_reg})
                    begin
                        short_next   = 1'b1;
                        elapsed_next = '0;
                        phase_next   = PH_SHORT;
                    end
                    else
                        elapsed_next = elapsed_inc;
                end
                PH_SHORT:
                begin
                    if (!active)
                        phase_next = PH_IDLE;
                    else
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > {1'b0, long_reg})
                        begin
                            long_flag_next = 1'b1;
                            phase_next     = PH_LONG;
                        end
                    end
                end
                PH_LONG:
                begin
                    if (!active)
                        phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            short_reg     <= 1'b0;
            long_flag_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            short_reg     <= short_next;
            long_flag_reg <= long_flag_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            m_data_reg <= {4'b0000, phase_next, long_flag_next, short_next};
    end

endmodule

>>> rtl/core/dslpd_checker.sv
`include "assert_macros.svh"

module dslpd_checker
    import dslpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // stalled result beat must hold
    `ASSERT_CLKD(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped or changed under stall")

    // every tick taken yields a result beat next cycle
    `ASSERT_CLKD(a_beat_result, clk, rst_n, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "tick produced no result")

    // flags must agree with the pressed phases
    `ASSERT_CLKD(a_flags_phase, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[3:2] == PH_LONG && m_axis_tdata[1:0] == 2'b11) || (m_axis_tdata[3:2] == PH_SHORT && m_axis_tdata[1:0] == 2'b01) || (m_axis_tdata[3:2] == PH_DEBOUNCE && m_axis_tdata[1:0] == 2'b00) || (m_axis_tdata[3:2] == PH_IDLE), "flags inconsistent with phase")

    // an empty output stage never blocks the input
    `ASSERT_CLKD(a_no_idle_stall, clk, rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

endmodule

bind debounced_short_long_press_detector_core dslpd_checker u_dslpd_checker (.*);
